### rtl/ucs_pkg.sv
// ----------------------------------------------------------------------------
// ucs_pkg - UTF-8 code point substitution, shared definitions
// Field widths, UTF-8 tag constants, the token that travels down the table
// chain and the channel payload types.
// ----------------------------------------------------------------------------
package ucs_pkg;

   localparam int ByteW  = 8;
   localparam int CodeW  = 21;
   localparam int IndexW = 7;

   // result queue between the chain and the output port
   localparam int QueueDepth  = 8;
   localparam int QueuePtrW   = 3;
   localparam int QueueCountW = 4;

   // lead byte classification
   localparam logic [ByteW-1:0] Mask2    = 8'hE0;
   localparam logic [ByteW-1:0] Mask3    = 8'hF0;
   localparam logic [ByteW-1:0] Mask4    = 8'hF8;
   localparam logic [ByteW-1:0] LeadTag2 = 8'hC0;
   localparam logic [ByteW-1:0] LeadTag3 = 8'hE0;
   localparam logic [ByteW-1:0] LeadTag4 = 8'hF0;
   localparam logic [ByteW-1:0] ContTag  = 8'h80;

   // encoding range limits
   localparam logic [CodeW-1:0] Max1 = 21'h00007F;
   localparam logic [CodeW-1:0] Max2 = 21'h0007FF;
   localparam logic [CodeW-1:0] Max3 = 21'h00FFFF;

   typedef enum logic [1:0] {
      TK_NONE   = 2'd0,
      TK_LOOKUP = 2'd1,
      TK_WRITE  = 2'd2
   } token_kind_type;

   // one slot of the chain: a table write or a code point lookup
   typedef struct packed {
      token_kind_type    kind;
      logic [IndexW-1:0] entry_index;
      logic [CodeW-1:0]  code;
      logic [ByteW-1:0]  data_byte;
      logic              enable;
      logic              hit;
   } token_type;

   typedef struct packed {
      logic              op;
      logic [ByteW-1:0]  in_byte;
      logic [IndexW-1:0] entry_index;
      logic [CodeW-1:0]  entry_code;
      logic [ByteW-1:0]  entry_byte;
      logic              entry_enable;
   } req_payload_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             end_of_run;
   } rsp_payload_type;

endpackage

### rtl/ucs_if.sv
// ----------------------------------------------------------------------------
// ucs_if - valid/ready channels of the substitution block
// One interface for the byte and table-write items, one for output bytes.
// ----------------------------------------------------------------------------
interface ucs_req_if;
   logic                     valid;
   logic                     ready;
   ucs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ucs_rsp_if;
   logic                     valid;
   logic                     ready;
   ucs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ucs_decoder.sv
// ----------------------------------------------------------------------------
// ucs_decoder - UTF-8 decoder at the head of the chain
// Collects lead and continuation bytes into a code point and issues one
// token per accepted item: a lookup, a table write or an empty slot.
// ----------------------------------------------------------------------------
module ucs_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  ucs_pkg::req_payload_type item,
   output ucs_pkg::token_type       tok_out
);
   import ucs_pkg::*;

   logic [1:0]       pending_ff, pending_in;
   logic [CodeW-1:0] accum_ff, accum_in;
   logic [CodeW-1:0] shifted;

   assign shifted = {accum_ff[CodeW-7:0], item.in_byte[5:0]};

   // decode the next byte, or pass a table write through
   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      tok_out    = '0;
      tok_out.kind = TK_NONE;
      if (accept) begin
         if (item.op) begin
            tok_out.kind        = TK_WRITE;
            tok_out.entry_index = item.entry_index;
            tok_out.code        = item.entry_code;
            tok_out.data_byte   = item.entry_byte;
            tok_out.enable      = item.entry_enable;
         end else if (pending_ff != 2'd0) begin
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               accum_in     = '0;
               tok_out.kind = TK_LOOKUP;
               tok_out.code = shifted;
            end else begin
               accum_in = shifted;
            end
         end else begin
            priority if (!item.in_byte[7]) begin
               tok_out.kind = TK_LOOKUP;
               tok_out.code = {{(CodeW-ByteW){1'b0}}, item.in_byte};
            end else if ((item.in_byte & Mask2) == LeadTag2) begin
               accum_in   = {{(CodeW-5){1'b0}}, item.in_byte[4:0]};
               pending_in = 2'd1;
            end else if ((item.in_byte & Mask3) == LeadTag3) begin
               accum_in   = {{(CodeW-4){1'b0}}, item.in_byte[3:0]};
               pending_in = 2'd2;
            end else if ((item.in_byte & Mask4) == LeadTag4) begin
               accum_in   = {{(CodeW-3){1'b0}}, item.in_byte[2:0]};
               pending_in = 2'd3;
            end else begin
               // drop a stray continuation or an invalid lead byte
               pending_in = pending_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         accum_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
      end
   end

`ifndef SYNTH
   // a lookup closes the code point
   a_lookup_closes: assert property (@(posedge clock) disable iff (reset)
      (tok_out.kind == TK_LOOKUP) |=> (pending_ff == 2'd0))
      else $error("decoder left bytes pending after a lookup");
   // a table write leaves an open code point untouched
   a_write_keeps: assert property (@(posedge clock) disable iff (reset)
      (tok_out.kind == TK_WRITE) |=> $stable(pending_ff) && $stable(accum_ff))
      else $error("table write disturbed the decoder");
   // nothing moves without an accepted item
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(pending_ff) && $stable(accum_ff))
      else $error("decoder state changed while idle");
`endif

endmodule

### rtl/ucs_cell.sv
// ----------------------------------------------------------------------------
// ucs_cell - one substitution table entry in the chain
// Holds a single entry, applies a write addressed to it and marks a passing
// lookup as a hit when the entry matches; later cells override earlier ones.
// ----------------------------------------------------------------------------
module ucs_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ucs_pkg::token_type tok_in,
   output ucs_pkg::token_type tok_out
);
   import ucs_pkg::*;

   logic             in_use_ff;
   logic [CodeW-1:0] code_ff;
   logic [ByteW-1:0] byte_ff;
   token_type        token_ff, token_in;
   logic             write_here;

   assign write_here = (tok_in.kind == TK_WRITE)
                       && (32'(tok_in.entry_index) == 32'(CELL_INDEX));

   // mark a hit on the passing lookup
   always_comb begin
      token_in = tok_in;
      if ((tok_in.kind == TK_LOOKUP) && in_use_ff && (code_ff == tok_in.code)) begin
         token_in.hit       = 1'b1;
         token_in.data_byte = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff     <= 1'b0;
         token_ff      <= '0;
      end else if (advance) begin
         token_ff <= token_in;
         if (write_here) begin
            in_use_ff <= tok_in.enable;
         end
      end
   end

   // entry payload, no reset
   always_ff @(posedge clock) begin
      if (advance && write_here) begin
         code_ff <= tok_in.code;
         byte_ff <= tok_in.data_byte;
      end
   end

   assign tok_out = token_ff;

`ifndef SYNTH
   // a hit can only come from a live entry
   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      advance && (tok_in.kind == TK_LOOKUP) && !tok_in.hit && !in_use_ff
      |=> !token_ff.hit)
      else $error("hit raised by an unused entry");
   // the chain holds while stalled
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(token_ff) && $stable(in_use_ff))
      else $error("cell moved while stalled");
   // a write reaches this entry on the next edge
   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      advance && write_here |=> (in_use_ff == $past(tok_in.enable)))
      else $error("table write lost");
`endif

endmodule

### rtl/ucs_out_queue.sv
// ----------------------------------------------------------------------------
// ucs_out_queue - UTF-8 encoder and result queue
// Turns a finished lookup into its replacement byte or its 1 to 4 byte
// encoding, queues it, hands bytes out one per item; drops an unmatched NUL.
// ----------------------------------------------------------------------------
module ucs_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ucs_pkg::token_type tok_in,
   output logic               room,
   ucs_rsp_if.source          rsp_chan
);
   import ucs_pkg::*;

   typedef struct packed {
      logic [3:0][ByteW-1:0] bytes;
      logic [1:0]            last;
   } run_type;

   run_type                entries_ff [QueueDepth];
   run_type                run;
   logic                   run_any;
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueCountW-1:0] count_ff, count_in;
   logic [1:0]             pos_ff, pos_in;
   logic                   push, pop, take, at_end;
   logic [CodeW-1:0]       cp;

   assign cp = tok_in.code;

   // encode the finished code point
   always_comb begin
      run       = '0;
      run_any   = 1'b0;
      if (tok_in.kind == TK_LOOKUP) begin
         run_any = 1'b1;
         priority if (tok_in.hit) begin
            run.bytes[0] = tok_in.data_byte;
         end else if (cp == '0) begin
            run_any = 1'b0;
         end else if (cp <= Max1) begin
            run.bytes[0] = cp[ByteW-1:0];
         end else if (cp <= Max2) begin
            run.bytes[0] = LeadTag2 | {3'b000, cp[10:6]};
            run.bytes[1] = ContTag | {2'b00, cp[5:0]};
            run.last     = 2'd1;
         end else if (cp <= Max3) begin
            run.bytes[0] = LeadTag3 | {4'b0000, cp[15:12]};
            run.bytes[1] = ContTag | {2'b00, cp[11:6]};
            run.bytes[2] = ContTag | {2'b00, cp[5:0]};
            run.last     = 2'd2;
         end else begin
            run.bytes[0] = LeadTag4 | {5'b00000, cp[20:18]};
            run.bytes[1] = ContTag | {2'b00, cp[17:12]};
            run.bytes[2] = ContTag | {2'b00, cp[11:6]};
            run.bytes[3] = ContTag | {2'b00, cp[5:0]};
            run.last     = 2'd3;
         end
      end
   end

   assign room     = (count_ff != QueueCountW'(QueueDepth));
   assign push     = advance && run_any;
   assign rsp_chan.valid = (count_ff != '0);
   assign take     = rsp_chan.valid && rsp_chan.ready;
   assign at_end   = (pos_ff == entries_ff[rd_ptr_ff].last);
   assign pop      = take && at_end;

   assign rsp_chan.payload.out_byte   = entries_ff[rd_ptr_ff].bytes[pos_ff];
   assign rsp_chan.payload.end_of_run = at_end;

   // advance pointers, count and byte position
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QueueCountW'(push) - QueueCountW'(pop);
      pos_in    = pos_ff;
      if (take) begin
         pos_in = at_end ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= run;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCountW'(QueueDepth))
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("push into a full result queue");
   a_empty_pos: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (pos_ff == 2'd0))
      else $error("byte position set on an empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count out of step");
`endif

endmodule

### rtl/utf8_codepoint_substitution.sv
// The token of the item that completes a code point is registered in each table cell
//   in turn and then written into the result queue, which offers its first byte.
// Throughput: one item per cycle in, one byte per cycle out while rsp_chan is ready; the
//   eight-run result queue absorbs multi-byte encodings and stalls the chain when full.
// Reset clears the decoder, the chain and every entry's in-use flag at once.
// ----------------------------------------------------------------------------
// utf8_codepoint_substitution - UTF-8 transcoder with code point substitution
// Decoder, a chain of table cells searched as the lookup passes, and an
// encoder with a small result queue.
// ----------------------------------------------------------------------------
module utf8_codepoint_substitution #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic      clock,
   input  logic      reset,
   ucs_req_if.sink   req_chan,
   ucs_rsp_if.source rsp_chan
);
   import ucs_pkg::*;

   token_type tok_chain [TABLE_ENTRIES+1];
   logic      advance;
   logic      accept;

   // the whole chain moves while the queue has room
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   ucs_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_chan.payload),
      .tok_out (tok_chain[0])
   );

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ucs_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1])
      );
   end

   ucs_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .tok_in   (tok_chain[TABLE_ENTRIES]),
      .room     (advance),
      .rsp_chan (rsp_chan)
   );

endmodule
